// ===== rtl/core/ael_pkg.sv =====
// Shared types and constants for the arithmetic expression lexer.
`default_nettype none

package ael_pkg;

  // Position counter wraps at this string length.
  localparam int unsigned MaxStringLen = 65536;
  localparam int unsigned PosW         = $clog2(MaxStringLen);
  localparam int unsigned StartW       = 16;

  // Entries in the queue between front and back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  localparam logic [7:0] CharNul  = 8'h00;
  localparam logic [7:0] CharEq   = 8'h3D;  // '='
  localparam logic [7:0] CharBang = 8'h21;  // '!'
  localparam logic [7:0] CharLt   = 8'h3C;  // '<'
  localparam logic [7:0] CharGt   = 8'h3E;  // '>'

  typedef enum logic [2:0] {
    CLS_END,
    CLS_SPACE,
    CLS_DIGIT,
    CLS_LEAD,
    CLS_PUNCT,
    CLS_INVALID
  } char_class_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_PENDING,
    MODE_ERROR
  } lexer_mode_e;

  typedef enum logic [1:0] {
    TOK_PUNCT   = 2'd0,
    TOK_NUMBER  = 2'd1,
    TOK_END     = 2'd2,
    TOK_INVALID = 2'd3
  } token_kind_e;

  // One classified character as it travels from front to back.
  typedef struct packed {
    logic [7:0]        char_code;
    char_class_e       cls;
    logic [StartW-1:0] pos;
  } lex_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/ael_front.sv =====
// Front end: accepts characters, classifies them and tags each with its position.
`default_nettype none

module ael_front import ael_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       queue_ready_i,
  output logic            push_o,
  output lex_item_t       item_o
);

  logic [PosW-1:0] pos_q, pos_d;
  char_class_e     cls;

  always_comb begin
    if (char_code_i == CharNul) begin
      cls = CLS_END;
    end else if (char_code_i == 8'd32 || (char_code_i >= 8'd9 && char_code_i <= 8'd13)) begin
      cls = CLS_SPACE;
    end else if (char_code_i >= 8'd48 && char_code_i <= 8'd57) begin
      cls = CLS_DIGIT;
    end else if (char_code_i == CharEq || char_code_i == CharBang ||
                 char_code_i == CharLt || char_code_i == CharGt) begin
      cls = CLS_LEAD;
    end else if ((char_code_i >= 8'd33 && char_code_i <= 8'd47) ||
                 (char_code_i >= 8'd58 && char_code_i <= 8'd64) ||
                 (char_code_i >= 8'd91 && char_code_i <= 8'd96) ||
                 (char_code_i >= 8'd123 && char_code_i <= 8'd126)) begin
      cls = CLS_PUNCT;
    end else begin
      cls = CLS_INVALID;
    end
  end

  assign in_ready_o       = queue_ready_i;
  assign push_o           = in_valid_i && queue_ready_i;
  assign item_o.char_code = char_code_i;
  assign item_o.cls       = cls;
  assign item_o.pos       = StartW'(pos_q);

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (cls == CLS_END || pos_q == PosW'(MaxStringLen - 1)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ael_queue.sv =====
// Small flop-based queue of classified characters between front and back.
`default_nettype none

module ael_queue import ael_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire lex_item_t push_item_i,
  output logic           ready_o,
  input  wire logic      pop_i,
  output logic           head_valid_o,
  output lex_item_t      head_item_o
);

  lex_item_t          entries_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]     count_q, count_d;

  assign ready_o      = count_q != (QPtrW+1)'(QueueDepth);
  assign head_valid_o = count_q != '0;
  assign head_item_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (QPtrW+1)'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - (QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ael_back.sv =====
// Back end: lexer state machine and output token register.
`default_nettype none

module ael_back import ael_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      head_valid_i,
  input  wire lex_item_t head_item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic [1:0]     token_kind_o,
  output logic [31:0]    number_value_o,
  output logic [7:0]     first_char_o,
  output logic [7:0]     second_char_o,
  output logic [7:0]     token_length_o,
  output logic [15:0]    start_position_o,
  output logic           value_overflow_o,
  output logic           last_of_run_o
);

  lexer_mode_e       mode_q, mode_d;
  logic [31:0]       acc_q, acc_d;
  logic              ovf_q, ovf_d;
  logic [7:0]        cnt_q, cnt_d;
  logic [7:0]        pend_q, pend_d;
  logic [StartW-1:0] start_q, start_d;

  logic              out_valid_q, out_valid_d;
  token_kind_e       kind_q, kind_d;
  logic [31:0]       value_q, value_d;
  logic [7:0]        c1_q, c1_d;
  logic [7:0]        c2_q, c2_d;
  logic [7:0]        len_q, len_d;
  logic [StartW-1:0] spos_q, spos_d;
  logic              rovf_q, rovf_d;
  logic              last_q, last_d;

  logic              emit, pop_req, do_idle, idle_emit, step, out_free;
  logic [7:0]        c;
  char_class_e       cls;
  logic [35:0]       prod;

  assign c         = head_item_i.char_code;
  assign cls       = head_item_i.cls;
  assign idle_emit = cls == CLS_END || cls == CLS_PUNCT || cls == CLS_INVALID;
  // acc * 10 + digit, wide enough to see the carry out of 32 bits
  assign prod      = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {32'b0, c[3:0]};
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    start_d = start_q;
    emit    = 1'b0;
    pop_req = 1'b1;
    do_idle = 1'b0;
    kind_d  = TOK_PUNCT;
    value_d = '0;
    c1_d    = '0;
    c2_d    = '0;
    len_d   = '0;
    spos_d  = head_item_i.pos;
    rovf_d  = 1'b0;
    last_d  = 1'b1;

    case (mode_q)
      MODE_IDLE: begin
        do_idle = 1'b1;
      end
      MODE_NUMBER: begin
        if (cls == CLS_DIGIT) begin
          acc_d = prod[31:0];
          if (prod[35:32] != 4'd0) begin
            ovf_d = 1'b1;
          end
          if (cnt_q != 8'hFF) begin
            cnt_d = cnt_q + 8'd1;
          end
        end else begin
          emit    = 1'b1;
          kind_d  = TOK_NUMBER;
          value_d = acc_q;
          len_d   = cnt_q;
          spos_d  = start_q;
          rovf_d  = ovf_q;
          mode_d  = MODE_IDLE;
          // closing char that itself emits gets a second pass as idle
          if (idle_emit) begin
            pop_req = 1'b0;
            last_d  = 1'b0;
          end else begin
            do_idle = 1'b1;
          end
        end
      end
      MODE_PENDING: begin
        emit   = 1'b1;
        kind_d = TOK_PUNCT;
        c1_d   = pend_q;
        spos_d = start_q;
        mode_d = MODE_IDLE;
        if (c == CharEq) begin
          c2_d  = c;
          len_d = 8'd2;
        end else begin
          len_d = 8'd1;
          if (idle_emit) begin
            pop_req = 1'b0;
            last_d  = 1'b0;
          end else begin
            do_idle = 1'b1;
          end
        end
      end
      MODE_ERROR: begin
        if (cls == CLS_END) begin
          emit   = 1'b1;
          kind_d = TOK_END;
          mode_d = MODE_IDLE;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase

    if (do_idle) begin
      case (cls)
        CLS_END: begin
          emit   = 1'b1;
          kind_d = TOK_END;
          mode_d = MODE_IDLE;
        end
        CLS_SPACE: begin
        end
        CLS_DIGIT: begin
          mode_d  = MODE_NUMBER;
          acc_d   = {28'b0, c[3:0]};
          ovf_d   = 1'b0;
          cnt_d   = 8'd1;
          start_d = head_item_i.pos;
        end
        CLS_LEAD: begin
          mode_d  = MODE_PENDING;
          pend_d  = c;
          start_d = head_item_i.pos;
        end
        CLS_PUNCT: begin
          emit   = 1'b1;
          kind_d = TOK_PUNCT;
          c1_d   = c;
          len_d  = 8'd1;
        end
        default: begin
          emit   = 1'b1;
          kind_d = TOK_INVALID;
          len_d  = 8'd1;
          mode_d = MODE_ERROR;
        end
      endcase
    end
  end

  assign step  = head_valid_i && (!emit || out_free);
  assign pop_o = step && pop_req;

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      pend_q      <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        mode_q  <= mode_d;
        acc_q   <= acc_d;
        ovf_q   <= ovf_d;
        cnt_q   <= cnt_d;
        pend_q  <= pend_d;
        start_q <= start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      c1_q    <= c1_d;
      c2_q    <= c2_d;
      len_q   <= len_d;
      spos_q  <= spos_d;
      rovf_q  <= rovf_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign token_kind_o     = kind_q;
  assign number_value_o   = value_q;
  assign first_char_o     = c1_q;
  assign second_char_o    = c2_q;
  assign token_length_o   = len_q;
  assign start_position_o = spos_q;
  assign value_overflow_o = rovf_q;
  assign last_of_run_o    = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/arith_expression_lexer.sv =====
// Top level of the arithmetic expression lexer: front, queue and back.
//
// The lexer takes input characters and emits tokens on a valid/ready output
// channel. A character that gives one token or none is retired by the back
// end in a single pass; a character that closes a number or a held operator
// and also gives a token of its own (punctuator, end, invalid) occupies the
// back end once per token. A 4-entry queue between the classifying front end
// and the back end absorbs these extra passes and output stalls, so input is
// taken at one character per cycle while the queue has room. An accepted
// character is written into the queue; when it reaches the head, its first
// token is registered into the output token register.
`default_nettype none

module arith_expression_lexer import ael_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_code_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       token_kind_o,
  output logic [31:0]      number_value_o,
  output logic [7:0]       first_char_o,
  output logic [7:0]       second_char_o,
  output logic [7:0]       token_length_o,
  output logic [15:0]      start_position_o,
  output logic             value_overflow_o,
  output logic             last_of_run_o
);

  logic      queue_ready, push, pop, head_valid;
  lex_item_t push_item, head_item;

  ael_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .queue_ready_i (queue_ready),
    .push_o        (push),
    .item_o        (push_item)
  );

  ael_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .ready_o      (queue_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  ael_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_item_i      (head_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .token_kind_o     (token_kind_o),
    .number_value_o   (number_value_o),
    .first_char_o     (first_char_o),
    .second_char_o    (second_char_o),
    .token_length_o   (token_length_o),
    .start_position_o (start_position_o),
    .value_overflow_o (value_overflow_o),
    .last_of_run_o    (last_of_run_o)
  );

  // End tokens are zero length and always close the run.
  a_end_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == TOK_END |-> token_length_o == 8'd0 && last_of_run_o)
    else $error("end token with nonzero length or not last");

  // Only a closed number or held operator can precede another token of the same char.
  a_not_last_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> token_kind_o == TOK_NUMBER || token_kind_o == TOK_PUNCT)
    else $error("non-last token of unexpected kind");

  // The second token of a char follows right after the first is taken.
  a_second_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o)
    else $error("second token of a transaction missing");

endmodule

`default_nettype wire

// ===== tb/sv/ael_token_checker.sv =====
// Token predictor and scoreboard for the arithmetic expression lexer.
module ael_token_checker
  import ael_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  char_code_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  token_kind_i,
  input  logic [31:0] number_value_i,
  input  logic [7:0]  first_char_i,
  input  logic [7:0]  second_char_i,
  input  logic [7:0]  token_length_i,
  input  logic [15:0] start_position_i,
  input  logic        value_overflow_i,
  input  logic        last_of_run_i,
  output int          mismatch_count_o,
  output int          token_backlog_o
);

  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  typedef struct {
    token_kind_e  kind;
    logic [31:0]  value;
    logic [7:0]   c1;
    logic [7:0]   c2;
    logic [7:0]   len;
    logic [15:0]  start;
    logic         ovf;
    logic         last;
  } token_t;

  token_t expected_tokens[$];
  token_t want;
  int     mismatches = 0;
  int     new_tokens;

  // predicted lexer state
  lexer_mode_e mode;
  logic [31:0] acc;
  logic        ovf_seen;
  logic [7:0]  ndig;
  logic [7:0]  held;
  logic [15:0] tok_start;
  logic [15:0] cpos;

  assign mismatch_count_o = mismatches;

  function automatic char_class_e classify(logic [7:0] c);
    if (c == CharNul) return CLS_END;
    if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) return CLS_SPACE;
    if (c >= ChZero && c <= ChNine) return CLS_DIGIT;
    if (c == CharEq || c == CharBang || c == CharLt || c == CharGt) return CLS_LEAD;
    // C-locale punctuation: the four printable ranges outside digits and letters
    if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
        (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126)) return CLS_PUNCT;
    return CLS_INVALID;
  endfunction

  function automatic void add_token(token_kind_e kind, logic [31:0] value, logic [7:0] c1,
                                    logic [7:0] c2, logic [7:0] len, logic [15:0] start,
                                    logic ovf);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.c1    = c1;
    t.c2    = c2;
    t.len   = len;
    t.start = start;
    t.ovf   = ovf;
    t.last  = 1'b0;
    expected_tokens.push_back(t);
    new_tokens++;
  endfunction

  // Byte seen with no token open.
  function automatic void start_token(logic [7:0] c, logic [15:0] pos);
    case (classify(c))
      CLS_END:   add_token(TOK_END, '0, '0, '0, 8'd0, pos, 1'b0);
      CLS_SPACE: ;
      CLS_DIGIT: begin
        mode      = MODE_NUMBER;
        acc       = 32'(c - ChZero);
        ovf_seen  = 1'b0;
        ndig      = 8'd1;
        tok_start = pos;
      end
      CLS_LEAD: begin
        mode      = MODE_PENDING;
        held      = c;
        tok_start = pos;
      end
      CLS_PUNCT: add_token(TOK_PUNCT, '0, c, '0, 8'd1, pos, 1'b0);
      default: begin
        add_token(TOK_INVALID, '0, '0, '0, 8'd1, pos, 1'b0);
        mode = MODE_ERROR;
      end
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] c);
    logic [15:0] pos;
    logic [63:0] wide;
    pos        = cpos;
    new_tokens = 0;
    case (mode)
      MODE_NUMBER: begin
        if (classify(c) == CLS_DIGIT) begin
          wide = 64'(acc) * 64'd10 + 64'(c - ChZero);
          if (wide[63:32] != '0) ovf_seen = 1'b1;
          acc = wide[31:0];
          if (ndig != 8'hFF) ndig++;
        end else begin
          add_token(TOK_NUMBER, acc, '0, '0, ndig, tok_start, ovf_seen);
          mode = MODE_IDLE;
          start_token(c, pos);
        end
      end
      MODE_PENDING: begin
        mode = MODE_IDLE;
        if (c == CharEq) begin
          add_token(TOK_PUNCT, '0, held, c, 8'd2, tok_start, 1'b0);
        end else begin
          add_token(TOK_PUNCT, '0, held, '0, 8'd1, tok_start, 1'b0);
          start_token(c, pos);
        end
      end
      MODE_ERROR: begin
        if (c == CharNul) begin
          mode = MODE_IDLE;
          add_token(TOK_END, '0, '0, '0, 8'd0, pos, 1'b0);
        end
      end
      default: start_token(c, pos);
    endcase
    if (c == CharNul) begin
      mode = MODE_IDLE;
      cpos = '0;
    end else begin
      cpos = pos + 16'd1;  // 16-bit wrap matches the 65536 string length
    end
    if (new_tokens > 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  function automatic void cmp_field(string label, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, label, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode      = MODE_IDLE;
      acc       = '0;
      ovf_seen  = 1'b0;
      ndig      = '0;
      held      = '0;
      tok_start = '0;
      cpos      = '0;
      expected_tokens.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: token kind %0d expected none got one", $time, token_kind_i);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          cmp_field("token_kind", want.kind, token_kind_i);
          cmp_field("number_value", want.value, number_value_i);
          cmp_field("first_char", want.c1, first_char_i);
          cmp_field("second_char", want.c2, second_char_i);
          cmp_field("token_length", want.len, token_length_i);
          cmp_field("start_position", want.start, start_position_i);
          cmp_field("value_overflow", want.ovf, value_overflow_i);
          cmp_field("last_of_run", want.last, last_of_run_i);
        end
      end
      if (in_valid_i && in_ready_i) predict_tokens(char_code_i);
    end
    token_backlog_o = expected_tokens.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the arithmetic expression lexer: stimulus, flow control, verdict.
module tb;
  import ael_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  char_code_i = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  token_kind_o;
  logic [31:0] number_value_o;
  logic [7:0]  first_char_o;
  logic [7:0]  second_char_o;
  logic [7:0]  token_length_o;
  logic [15:0] start_position_o;
  logic        value_overflow_o;
  logic        last_of_run_o;

  int mismatch_total;
  int token_backlog;

  bit         gaps_on     = 1'b0;
  bit         quiet       = 1'b0;
  int         hold_cycles = 0;
  int         idle_left   = 0;
  int         items_sent  = 0;
  logic [7:0] text[$];

  arith_expression_lexer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .char_code_i,
    .out_valid_o, .out_ready_i, .token_kind_o, .number_value_o,
    .first_char_o, .second_char_o, .token_length_o, .start_position_o,
    .value_overflow_o, .last_of_run_o
  );

  ael_token_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .char_code_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .token_kind_i(token_kind_o), .number_value_i(number_value_o),
    .first_char_i(first_char_o), .second_char_i(second_char_o),
    .token_length_i(token_length_o), .start_position_i(start_position_o),
    .value_overflow_i(value_overflow_o), .last_of_run_i(last_of_run_o),
    .mismatch_count_o(mismatch_total), .token_backlog_o(token_backlog)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Token sink: a requested long hold-off first, then random idle bursts.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else if (idle_left != 0) begin
        out_ready_i <= 1'b0;
        idle_left--;
      end else if (gaps_on && !quiet && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        idle_left = $urandom_range(0, 6);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic put_char(input logic [7:0] c);
    int unsigned gap;
    gap = 0;
    if (gaps_on && !quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  task automatic send_text();
    foreach (text[i]) put_char(text[i]);
    put_char(CharNul);
    text.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (token_backlog != 0) @(negedge clk_i);
  endtask

  task automatic add_spaces();
    int n;
    n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
    repeat (n) text.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(9, 13)) : 8'd32);
  endtask

  task automatic add_number();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
    repeat (n) text.push_back(8'h30 + 8'($urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] rand_punct();
    int r;
    r = $urandom_range(0, 31);
    if (r < 15) return 8'(33 + r);
    if (r < 22) return 8'(58 + r - 15);
    if (r < 28) return 8'(91 + r - 22);
    return 8'(123 + r - 28);
  endfunction

  function automatic logic [7:0] rand_lead();
    case ($urandom_range(0, 3))
      0:       return CharEq;
      1:       return CharBang;
      2:       return CharLt;
      default: return CharGt;
    endcase
  endfunction

  function automatic logic [7:0] rand_invalid();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(1, 8));
      1:       return 8'($urandom_range(14, 31));
      2:       return 8'h7F;
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic add_op();
    case ($urandom_range(0, 2))
      0: begin
        text.push_back(rand_lead());
        text.push_back(CharEq);
      end
      1:       text.push_back(rand_lead());
      default: text.push_back(rand_punct());
    endcase
  endtask

  task automatic build_expr();
    int nterms;
    nterms = $urandom_range(1, 6);
    for (int t = 0; t < nterms; t++) begin
      if ($urandom_range(0, 5) == 0) text.push_back(8'h28);
      add_spaces();
      add_number();
      add_spaces();
      if (t < nterms - 1 || $urandom_range(0, 3) == 0) add_op();
    end
  endtask

  initial begin
    bit stall_done;
    bit pause_done;
    int r;
    stall_done = 1'b0;
    pause_done = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // two-char operators, held operators that do not pair, "===" and end after a held one
    gaps_on = 1'b1;
    put_text("<=>=!===<>!");
    put_char(CharNul);
    // numbers closed by each kind of byte, invalid byte after a number, dropped bytes
    put_text("9=7\t5~3");
    put_char(8'h7F);
    put_text(" 2");
    put_char(CharNul);
    put_char(8'hFF);
    put_char(8'h80);
    put_char(8'h01);
    put_char(CharNul);
    put_char(CharNul);
    put_text("\r4294967295 4294967296");
    put_char(CharNul);
    wait_drained();

    // long number: digit count saturates, value wraps
    gaps_on = 1'b0;
    text.push_back(8'h31);
    repeat (299) text.push_back(8'h30 + 8'($urandom_range(0, 9)));
    send_text();
    wait_drained();

    while (items_sent < 1850) begin
      quiet   = (items_sent > 1550);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (!stall_done && items_sent > 600) begin
        hold_cycles = 60;
        stall_done  = 1'b1;
      end
      if (!pause_done && items_sent > 1100) begin
        wait_drained();
        pause_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        build_expr();
      end else if (r < 85) begin
        build_expr();
        text.insert($urandom_range(0, text.size()), rand_invalid());
      end else begin
        repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(1, 255)));
      end
      send_text();
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (mismatch_total == 0 && token_backlog == 0) begin
      $display("PASS arith_expression_lexer");
    end else begin
      $display("FAIL arith_expression_lexer");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL arith_expression_lexer");
    $finish;
  end

endmodule

// ===== arith_expression_lexer.f =====
rtl/core/ael_pkg.sv
rtl/core/ael_front.sv
rtl/core/ael_queue.sv
rtl/core/ael_back.sv
rtl/core/arith_expression_lexer.sv
tb/sv/ael_token_checker.sv
tb/sv/tb.sv
